[rtl/bpa_pkg.sv]
// Shared constants, types and helpers for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  // Default configuration of the allocator.
  localparam int MAP_WORDS_DEF     = 32768;
  localparam int BITS_PER_WORD_DEF = 32;
  localparam int PAGE_SHIFT_DEF    = 12;

  // Width of a byte address on the request and result ports.
  localparam int ADDR_W = 32;

  // Each summary word flags 32 entries of the level below it.
  localparam int SUM_BITS  = 32;
  localparam int SUM_SHIFT = 5;

  // A map word index is three summary digits: top bit, level 2 bit, level 1 bit.
  localparam int IDX_W = 3 * SUM_SHIFT;

  // Operation codes of the func field.
  localparam logic FUNC_FREE  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Enables for the bitmap and summary memories.
  typedef struct packed {
    logic rd;
    logic wr_map;
    logic wr_l1;
    logic wr_l2;
  } bpa_mem_ctl_t;

  // Address width for a memory of the given depth, at least one bit.
  function automatic int addr_width(input int depth);
    int w;
    w = (depth > 1) ? $clog2(depth) : 1;
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/bpa_ffs.sv]
// Find-first-set unit shared by every level of the bitmap search.
`default_nettype none

module bpa_ffs
  import bpa_pkg::*;
#(
  parameter int WIDTH = SUM_BITS
) (
  input  wire logic [WIDTH-1:0]         vec,
  output logic      [$clog2(WIDTH)-1:0] idx,
  output logic                          any
);

  localparam int IW = $clog2(WIDTH);

  // Priority encode: the lowest set bit wins.
  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
    any = |vec;
  end

endmodule

`default_nettype wire

[rtl/bpa_store.sv]
// Free-page bitmap memory and its two levels of nonzero-word summaries.
`default_nettype none

module bpa_store
  import bpa_pkg::*;
#(
  parameter int MAP_WORDS     = MAP_WORDS_DEF,
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
  input  wire logic                     clk,
  input  wire bpa_mem_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]         rd_idx,
  input  wire logic [IDX_W-1:0]         wr_idx,
  input  wire logic [BITS_PER_WORD-1:0] map_wdata,
  input  wire logic [SUM_BITS-1:0]      l1_wdata,
  input  wire logic [SUM_BITS-1:0]      l2_wdata,
  output logic      [BITS_PER_WORD-1:0] map_rdata,
  output logic      [SUM_BITS-1:0]      l1_rdata,
  output logic      [SUM_BITS-1:0]      l2_rdata
);

  localparam int L1_WORDS = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int L2_WORDS = (L1_WORDS + SUM_BITS - 1) / SUM_BITS;
  localparam int MW_AW    = addr_width(MAP_WORDS);
  localparam int L1_AW    = addr_width(L1_WORDS);
  localparam int L2_AW    = addr_width(L2_WORDS);

  logic [BITS_PER_WORD-1:0] map_mem [MAP_WORDS];
  logic [SUM_BITS-1:0]      l1_mem  [L1_WORDS];
  logic [SUM_BITS-1:0]      l2_mem  [L2_WORDS];

  logic [MW_AW-1:0] map_wa, map_ra;
  logic [L1_AW-1:0] l1_wa, l1_ra;
  logic [L2_AW-1:0] l2_wa, l2_ra;

  // Each level is addressed by the word index with its low digits dropped.
  assign map_wa = wr_idx[MW_AW-1:0];
  assign map_ra = rd_idx[MW_AW-1:0];
  assign l1_wa  = wr_idx[L1_AW+SUM_SHIFT-1:SUM_SHIFT];
  assign l1_ra  = rd_idx[L1_AW+SUM_SHIFT-1:SUM_SHIFT];
  assign l2_wa  = wr_idx[L2_AW+2*SUM_SHIFT-1:2*SUM_SHIFT];
  assign l2_ra  = rd_idx[L2_AW+2*SUM_SHIFT-1:2*SUM_SHIFT];

  // Bitmap words.
  always_ff @(posedge clk) begin
    if (ctl.wr_map) begin
      map_mem[map_wa] <= map_wdata;
    end
    if (ctl.rd) begin
      map_rdata <= map_mem[map_ra];
    end
  end

  // First summary level: one bit per bitmap word that holds a free page.
  always_ff @(posedge clk) begin
    if (ctl.wr_l1) begin
      l1_mem[l1_wa] <= l1_wdata;
    end
    if (ctl.rd) begin
      l1_rdata <= l1_mem[l1_ra];
    end
  end

  // Second summary level: one bit per nonzero first-level word.
  always_ff @(posedge clk) begin
    if (ctl.wr_l2) begin
      l2_mem[l2_wa] <= l2_wdata;
    end
    if (ctl.rd) begin
      l2_rdata <= l2_mem[l2_ra];
    end
  end

endmodule

`default_nettype wire

[rtl/bitmap_page_allocator.sv]
// Allocate reads the two summary levels and then the bitmap, claims the page and then
// registers its byte address; it ends early when no page is free. Free splits the page
// number, reads the word and writes it back, and ends early when the page lies beyond
// the map. busy drops in the done cycle, so a new start can be accepted in that cycle.
// Reset: a clearing pass over all MAP_WORDS words zeroes the bitmap
// and summaries while busy is high; done is never held off by the receiver.
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAP_WORDS     = MAP_WORDS_DEF,
  parameter int BITS_PER_WORD = BITS_PER_WORD_DEF,
  parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func,
  input  wire logic [ADDR_W-1:0] page_address,
  output logic                   done,
  output logic      [ADDR_W-1:0] alloc_address,
  output logic                   found
);

  localparam int PAGE_BITS = ADDR_W - PAGE_SHIFT;
  localparam int BB        = $clog2(BITS_PER_WORD);
  localparam int FW        = (BITS_PER_WORD > SUM_BITS) ? BITS_PER_WORD : SUM_BITS;
  localparam int FB        = $clog2(FW);
  localparam int MW_AW     = addr_width(MAP_WORDS);
  localparam int PG_W      = MW_AW + BB + 1;
  // Reciprocal of the word width, exact for every PAGE_BITS-bit page number.
  localparam int DIV_SH    = PAGE_BITS + BB;
  localparam int MUL_W     = PAGE_BITS + 1;
  localparam int PROD_W    = PAGE_BITS + DIV_SH;
  localparam logic [MUL_W-1:0] MUL_M =
    MUL_W'(((1 << DIV_SH) + BITS_PER_WORD - 1) / BITS_PER_WORD);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_WORDS - 1);
  localparam logic [PAGE_BITS-1:0] BPW_P  = PAGE_BITS'(BITS_PER_WORD);
  localparam logic [PAGE_BITS-1:0] MAP_P  = PAGE_BITS'(MAP_WORDS);

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_A_TOP = 4'd2;
  localparam logic [3:0] ST_A_L2  = 4'd3;
  localparam logic [3:0] ST_A_L1  = 4'd4;
  localparam logic [3:0] ST_A_MAP = 4'd5;
  localparam logic [3:0] ST_A_OUT = 4'd6;
  localparam logic [3:0] ST_F_MUL = 4'd7;
  localparam logic [3:0] ST_F_DIV = 4'd8;
  localparam logic [3:0] ST_F_RD  = 4'd9;
  localparam logic [3:0] ST_F_WR  = 4'd10;

  logic [3:0]           state;
  logic [IDX_W-1:0]     widx;
  logic [SUM_BITS-1:0]  top_sum;
  logic [BB-1:0]        bitsel;
  logic                 in_range;
  logic [PAGE_BITS-1:0] page_r;
  logic [PROD_W-1:0]    prod;

  bpa_mem_ctl_t             mem_ctl;
  logic [IDX_W-1:0]         rd_idx;
  logic [BITS_PER_WORD-1:0] map_wdata, map_rdata;
  logic [SUM_BITS-1:0]      l1_wdata, l1_rdata;
  logic [SUM_BITS-1:0]      l2_wdata, l2_rdata;

  logic [FW-1:0] ffs_vec;
  logic [FB-1:0] ffs_idx;
  logic          ffs_any;

  logic [BB-1:0]        cur_bit;
  logic [PAGE_BITS-1:0] quo, quo_bpw, rem, quo_c, rem_c;
  logic                 rem_fix;
  logic [PG_W-1:0]      page_num;
  logic [PG_W+PAGE_SHIFT-1:0] byte_addr;

  bpa_store #(
    .MAP_WORDS     (MAP_WORDS),
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (widx),
    .map_wdata (map_wdata),
    .l1_wdata  (l1_wdata),
    .l2_wdata  (l2_wdata),
    .map_rdata (map_rdata),
    .l1_rdata  (l1_rdata),
    .l2_rdata  (l2_rdata)
  );

  bpa_ffs #(
    .WIDTH (FW)
  ) u_ffs (
    .vec (ffs_vec),
    .idx (ffs_idx),
    .any (ffs_any)
  );

  assign busy = (state != ST_IDLE);

  // The one find-first unit looks at whichever level the search has reached.
  always_comb begin
    case (state)
      ST_A_L2:  ffs_vec = FW'(l2_rdata);
      ST_A_L1:  ffs_vec = FW'(l1_rdata);
      ST_A_MAP: ffs_vec = FW'(map_rdata);
      default:  ffs_vec = FW'(top_sum);
    endcase
  end

  // Page number split into word and bit by reciprocal multiply and one correction.
  always_comb begin
    quo     = prod[PROD_W-1:DIV_SH];
    quo_bpw = quo * BPW_P;
    rem     = page_r - quo_bpw;
    rem_fix = (rem >= BPW_P);
    quo_c   = rem_fix ? quo + PAGE_BITS'(1) : quo;
    rem_c   = rem_fix ? rem - BPW_P : rem;
  end

  // Byte address of the claimed page.
  always_comb begin
    page_num  = PG_W'(widx[MW_AW-1:0]) * PG_W'(BITS_PER_WORD) + PG_W'(bitsel);
    byte_addr = {page_num, {PAGE_SHIFT{1'b0}}};
  end

  // Memory reads, and the read-modify-write of the bitmap and its summaries.
  always_comb begin
    mem_ctl   = '0;
    rd_idx    = widx;
    cur_bit   = (state == ST_A_MAP) ? ffs_idx[BB-1:0] : bitsel;
    map_wdata = '0;
    l1_wdata  = '0;
    l2_wdata  = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_ctl.wr_map = 1'b1;
        mem_ctl.wr_l1  = 1'b1;
        mem_ctl.wr_l2  = 1'b1;
      end
      ST_A_TOP: begin
        mem_ctl.rd = ffs_any;
        rd_idx     = {ffs_idx[SUM_SHIFT-1:0], {2*SUM_SHIFT{1'b0}}};
      end
      ST_A_L2: begin
        mem_ctl.rd = 1'b1;
        rd_idx     = {widx[IDX_W-1:2*SUM_SHIFT], ffs_idx[SUM_SHIFT-1:0],
                      {SUM_SHIFT{1'b0}}};
      end
      ST_A_L1: begin
        mem_ctl.rd = 1'b1;
        rd_idx     = {widx[IDX_W-1:SUM_SHIFT], ffs_idx[SUM_SHIFT-1:0]};
      end
      ST_A_MAP: begin
        // Claim the page; a summary bit drops only when the word below empties.
        map_wdata      = map_rdata & ~(BITS_PER_WORD'(1) << cur_bit);
        l1_wdata       = l1_rdata & ~(SUM_BITS'(1) << widx[SUM_SHIFT-1:0]);
        l2_wdata       = l2_rdata & ~(SUM_BITS'(1) << widx[2*SUM_SHIFT-1:SUM_SHIFT]);
        mem_ctl.wr_map = 1'b1;
        mem_ctl.wr_l1  = (map_wdata == '0);
        mem_ctl.wr_l2  = mem_ctl.wr_l1 && (l1_wdata == '0);
      end
      ST_F_RD: begin
        mem_ctl.rd = in_range;
      end
      ST_F_WR: begin
        // The word now holds a free page, so every summary above it is set.
        map_wdata      = map_rdata | (BITS_PER_WORD'(1) << cur_bit);
        l1_wdata       = l1_rdata | (SUM_BITS'(1) << widx[SUM_SHIFT-1:0]);
        l2_wdata       = l2_rdata | (SUM_BITS'(1) << widx[2*SUM_SHIFT-1:SUM_SHIFT]);
        mem_ctl.wr_map = 1'b1;
        mem_ctl.wr_l1  = 1'b1;
        mem_ctl.wr_l2  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      widx    <= '0;
      top_sum <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          widx <= widx + IDX_W'(1);
          if (widx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            page_r <= page_address[ADDR_W-1:PAGE_SHIFT];
            state  <= (func == FUNC_ALLOC) ? ST_A_TOP : ST_F_MUL;
          end
        end
        ST_A_TOP: begin
          if (ffs_any) begin
            widx[IDX_W-1:2*SUM_SHIFT] <= ffs_idx[SUM_SHIFT-1:0];
            state                     <= ST_A_L2;
          end else begin
            alloc_address <= '0;
            found         <= 1'b0;
            done          <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_A_L2: begin
          widx[2*SUM_SHIFT-1:SUM_SHIFT] <= ffs_idx[SUM_SHIFT-1:0];
          state                         <= ST_A_L1;
        end
        ST_A_L1: begin
          widx[SUM_SHIFT-1:0] <= ffs_idx[SUM_SHIFT-1:0];
          state               <= ST_A_MAP;
        end
        ST_A_MAP: begin
          bitsel <= cur_bit;
          if (mem_ctl.wr_l2 && (l2_wdata == '0)) begin
            top_sum[widx[IDX_W-1:2*SUM_SHIFT]] <= 1'b0;
          end
          state <= ST_A_OUT;
        end
        ST_A_OUT: begin
          alloc_address <= ADDR_W'(byte_addr);
          found         <= 1'b1;
          done          <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_F_MUL: begin
          prod  <= PROD_W'(page_r) * PROD_W'(MUL_M);
          state <= ST_F_DIV;
        end
        ST_F_DIV: begin
          widx     <= quo_c[IDX_W-1:0];
          bitsel   <= rem_c[BB-1:0];
          in_range <= (quo_c < MAP_P);
          state    <= ST_F_RD;
        end
        ST_F_RD: begin
          if (in_range) begin
            state <= ST_F_WR;
          end else begin
            alloc_address <= '0;
            found         <= 1'b0;
            done          <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_F_WR: begin
          top_sum[widx[IDX_W-1:2*SUM_SHIFT]] <= 1'b1;
          alloc_address                      <= '0;
          found                              <= 1'b0;
          done                               <= 1'b1;
          state                              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the bitmap page allocator: directed and random free/allocate traffic.
`timescale 1ns / 100ps

import bpa_pkg::*;

// Tracks which pages should be free and the grants the allocator owes.
class page_grant_board;
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              found;
  } grant_t;

  bit          free_pages[int unsigned];
  grant_t      expected_grants[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned frees;
  int unsigned grants;
  int unsigned empty_allocs;

  function new();
    mismatches   = 0;
    checked      = 0;
    frees        = 0;
    grants       = 0;
    empty_allocs = 0;
  endfunction

  // Applies an accepted transaction to the page set and queues its result.
  function void note_request(logic op, logic [ADDR_W-1:0] addr);
    int unsigned page;
    grant_t      g;
    g.addr  = '0;
    g.found = 1'b0;
    if (op == FUNC_FREE) begin
      // Pages past the last map word are dropped.
      page = addr >> PAGE_SHIFT_DEF;
      if ((page / BITS_PER_WORD_DEF) < MAP_WORDS_DEF) begin
        free_pages[page] = 1'b1;
      end
      frees++;
    end else if (free_pages.first(page)) begin
      // The lowest free page number wins.
      free_pages.delete(page);
      g.addr  = page << PAGE_SHIFT_DEF;
      g.found = 1'b1;
      grants++;
    end else begin
      empty_allocs++;
    end
    expected_grants.push_back(g);
  endfunction

  // Compares one result transaction against the oldest expectation.
  function void check_grant(logic [ADDR_W-1:0] addr, logic found);
    grant_t g;
    if (expected_grants.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result with nothing pending: alloc_address=%h found=%b",
                 addr, found);
      end
      return;
    end
    g = expected_grants.pop_front();
    checked++;
    if (addr !== g.addr || found !== g.found) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d: expected alloc_address=%h found=%b, got alloc_address=%h found=%b",
                 checked, g.addr, g.found, addr, found);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_grants.size();
  endfunction
endclass

module tb_top;

  localparam int ITEM_COUNT = 1650;
  localparam int TOP_PAGE   = MAP_WORDS_DEF * BITS_PER_WORD_DEF - 1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              func = FUNC_FREE;
  logic [ADDR_W-1:0] page_address = '0;
  logic              busy;
  logic              done;
  logic [ADDR_W-1:0] alloc_address;
  logic              found;

  page_grant_board board = new();
  int unsigned     issued = 0;
  bit              no_idle = 1'b0;

  bitmap_page_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .page_address  (page_address),
    .done          (done),
    .alloc_address (alloc_address),
    .found         (found)
  );

  always #4 clk = ~clk;

  // Every result transaction is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      board.check_grant(alloc_address, found);
    end
  end

  // Sends one request after an optional idle gap and waits until it is taken.
  task automatic issue(input logic op, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= op;
    page_address <= addr;
    do @(posedge clk); while (busy);
    board.note_request(op, addr);
    issued++;
  endtask

  initial begin
    int unsigned       phase_len;
    int unsigned       alloc_pct;
    int unsigned       pg;
    logic              op;
    logic [ADDR_W-1:0] addr;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Let the clearing pass after reset finish.
    @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: empty map, page zero, repeated free, word boundary, top page.
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_FREE, 32'h0000_0FFF);
    issue(FUNC_FREE, 32'h0000_0000);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_FREE, 32'hFFFF_FFFF);
    issue(FUNC_FREE, 32'h0001_F000);
    issue(FUNC_FREE, 32'h0002_0ABC);
    issue(FUNC_ALLOC, 32'h0000_0000);
    issue(FUNC_ALLOC, 32'hFFFF_FFFF);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_FREE, 32'h8000_0000);
    issue(FUNC_FREE, 32'h7FFF_F000);
    issue(FUNC_FREE, 32'h5555_5555);
    issue(FUNC_FREE, 32'hAAAA_AAAA);
    issue(FUNC_FREE, 32'h5555_5555);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);
    issue(FUNC_ALLOC, $urandom);

    // Random phases, each with an allocate share of 10, 50 or 90 percent, fill and drain the map.
    while (issued < ITEM_COUNT) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 10;
        1:       alloc_pct = 50;
        default: alloc_pct = 90;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && issued < ITEM_COUNT; k++) begin
        op = ($urandom_range(1, 100) <= alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
        case ($urandom_range(0, 3))
          0:       pg = $urandom_range(0, 255);
          1:       pg = $urandom_range(0, 63) * BITS_PER_WORD_DEF +
                        ($urandom_range(0, 1) ? BITS_PER_WORD_DEF - 1 : 0);
          2:       pg = TOP_PAGE - $urandom_range(0, 63);
          default: pg = $urandom >> PAGE_SHIFT_DEF;
        endcase
        addr = (pg << PAGE_SHIFT_DEF) | ($urandom & ((1 << PAGE_SHIFT_DEF) - 1));
        issue(op, addr);
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for the block's latency.
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d transactions: %0d frees, %0d granted allocations, %0d on an empty map.",
             issued, board.frees, board.grants, board.empty_allocs);
    $display("%0d results checked, %0d mismatches, %0d pages left free.",
             board.checked, board.mismatches, board.free_pages.num());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run, clearing pass included.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still pending.", board.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule

[bitmap_page_allocator.f]
rtl/bpa_pkg.sv
rtl/bpa_ffs.sv
rtl/bpa_store.sv
rtl/bitmap_page_allocator.sv
bench/tb_top.sv
